FILE: rtl/assert_macros.svh
// Assertion helpers for the converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define Q2E_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define Q2E_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q2E_ASSERT(lbl, clk, rst, prop, msg)
`define Q2E_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/q2e_pkg.sv
package q2e_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int CW                  = 40;
   localparam int ZW                  = 28;
   localparam int SQRT_CELLS          = 32;

   localparam logic signed [ZW-1:0] DEG90  = ZW'(5898240);
   localparam logic signed [ZW-1:0] DEG180 = ZW'(11796480);
   localparam logic signed [ZW-1:0] DEG360 = ZW'(23592960);

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic [15:0]        yaw_angle;
      logic               zero_norm;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic              zero;
      logic signed [CW-1:0] roll_y;
      logic signed [CW-1:0] roll_x;
      logic signed [CW-1:0] yaw_y;
      logic signed [CW-1:0] yaw_x;
      logic signed [CW-1:0] u;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [63:0] v;
      logic [63:0] r;
   } sqrt_type;

   typedef struct packed {
      logic                 valid;
      logic                 tag;
      logic                 fix;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] t;
      case (i)
         0:       t = ZW'(2949120);
         1:       t = ZW'(1740967);
         2:       t = ZW'(919879);
         3:       t = ZW'(466945);
         4:       t = ZW'(234379);
         5:       t = ZW'(117304);
         6:       t = ZW'(58666);
         7:       t = ZW'(29335);
         8:       t = ZW'(14668);
         9:       t = ZW'(7334);
         10:      t = ZW'(3667);
         11:      t = ZW'(1833);
         12:      t = ZW'(917);
         13:      t = ZW'(458);
         14:      t = ZW'(229);
         15:      t = ZW'(115);
         16:      t = ZW'(57);
         17:      t = ZW'(29);
         18:      t = ZW'(14);
         19:      t = ZW'(7);
         20:      t = ZW'(4);
         21:      t = ZW'(2);
         22:      t = ZW'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic cordic_type cordic_init(input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] x);
      cordic_type c;
      c       = '0;
      c.x     = x;
      c.y     = y;
      if (y == 0) begin
         c.fix = 1'b1;
         c.z   = (x < 0) ? DEG180 : '0;
      end else if (x == 0) begin
         c.fix = 1'b1;
         c.z   = (y > 0) ? DEG90 : -DEG90;
      end else if (x < 0) begin
         c.z = (y >= 0) ? DEG180 : -DEG180;
         c.x = -x;
         c.y = -y;
      end
      return c;
   endfunction

endpackage

FILE: rtl/q2e_front.sv
module q2e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  q2e_pkg::req_type  in_data,
   output q2e_pkg::sqrt_type out_data
);

   localparam int CW = q2e_pkg::CW;

   logic               v1_ff, z1_ff;
   logic signed [16:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic               v2_ff, z2_ff;
   logic signed [17:0] a2_ff, b2_ff, c2_ff, d2_ff;
   logic               v3_ff, z3_ff;
   logic signed [35:0] aa_ff, bb_ff, cc_ff, dd_ff, bc_ff, ad_ff, ab_ff, cd_ff, bd_ff, ac_ff;
   q2e_pkg::side_type  s4_ff, s4_in, s5_ff, s5_in;
   logic signed [CW-1:0] n2_ff, n2_in, ur_ff, ur_in;
   logic [31:0]        p_ff, q_ff, p_in, q_in;
   q2e_pkg::sqrt_type  s6_ff;

   logic signed [16:0] a_in, b_in, c_in, d_in;
   logic [16:0]        ma, mb, mc, md, m;
   logic [3:0]         hb;
   logic [3:0]         sh;
   logic signed [CW-1:0] dm, dp;

   always_comb begin
      a_in = {in_data.quat_x[15], in_data.quat_x} + {in_data.quat_y[15], in_data.quat_y};
      b_in = {in_data.quat_y[15], in_data.quat_y} - {in_data.quat_x[15], in_data.quat_x};
      c_in = {in_data.quat_z[15], in_data.quat_z} - {in_data.quat_w[15], in_data.quat_w};
      d_in = {in_data.quat_w[15], in_data.quat_w} + {in_data.quat_z[15], in_data.quat_z};
   end

   always_comb begin
      ma = a1_ff[16] ? 17'(-a1_ff) : 17'(a1_ff);
      mb = b1_ff[16] ? 17'(-b1_ff) : 17'(b1_ff);
      mc = c1_ff[16] ? 17'(-c1_ff) : 17'(c1_ff);
      md = d1_ff[16] ? 17'(-d1_ff) : 17'(d1_ff);
      m  = ma;
      if (mb > m) m = mb;
      if (mc > m) m = mc;
      if (md > m) m = md;
      hb = '0;
      for (int i = 0; i < 16; i++) begin
         if (m[i]) hb = 4'(i);
      end
      sh = (m[16] || m[15]) ? 4'd0 : 4'(4'd15 - hb);
   end

   always_comb begin
      s4_in        = '0;
      s4_in.valid  = v3_ff;
      s4_in.zero   = z3_ff;
      s4_in.roll_y = (CW'(bc_ff) + CW'(ad_ff)) <<< 1;
      s4_in.roll_x = CW'(aa_ff) + CW'(bb_ff) - CW'(cc_ff) - CW'(dd_ff);
      s4_in.yaw_y  = (CW'(ab_ff) + CW'(cd_ff)) <<< 1;
      s4_in.yaw_x  = CW'(aa_ff) - CW'(bb_ff) - CW'(cc_ff) + CW'(dd_ff);
      n2_in        = CW'(aa_ff) + CW'(bb_ff) + CW'(cc_ff) + CW'(dd_ff);
      ur_in        = (CW'(bd_ff) - CW'(ac_ff)) <<< 1;
   end

   always_comb begin
      s5_in = s4_ff;
      if (ur_ff > n2_ff) begin
         s5_in.u = n2_ff;
      end else if (ur_ff < -n2_ff) begin
         s5_in.u = -n2_ff;
      end else begin
         s5_in.u = ur_ff;
      end
      dm   = n2_ff - s5_in.u;
      dp   = n2_ff + s5_in.u;
      p_in = dm[35:4];
      q_in = dp[35:4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.side.valid <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         z1_ff <= (a_in == 0) && (b_in == 0) && (c_in == 0) && (d_in == 0);
         a1_ff <= a_in;
         b1_ff <= b_in;
         c1_ff <= c_in;
         d1_ff <= d_in;
         v2_ff <= v1_ff;
         z2_ff <= z1_ff;
         a2_ff <= 18'(a1_ff) <<< sh;
         b2_ff <= 18'(b1_ff) <<< sh;
         c2_ff <= 18'(c1_ff) <<< sh;
         d2_ff <= 18'(d1_ff) <<< sh;
         v3_ff <= v2_ff;
         z3_ff <= z2_ff;
         aa_ff <= a2_ff * a2_ff;
         bb_ff <= b2_ff * b2_ff;
         cc_ff <= c2_ff * c2_ff;
         dd_ff <= d2_ff * d2_ff;
         bc_ff <= b2_ff * c2_ff;
         ad_ff <= a2_ff * d2_ff;
         ab_ff <= a2_ff * b2_ff;
         cd_ff <= c2_ff * d2_ff;
         bd_ff <= b2_ff * d2_ff;
         ac_ff <= a2_ff * c2_ff;
         s4_ff <= s4_in;
         n2_ff <= n2_in;
         ur_ff <= ur_in;
         s5_ff <= s5_in;
         p_ff  <= p_in;
         q_ff  <= q_in;
         s6_ff.side <= s5_ff;
         s6_ff.v    <= 64'(p_ff) * 64'(q_ff);
         s6_ff.r    <= '0;
      end
   end

   assign out_data = s6_ff;

endmodule

FILE: rtl/q2e_sqrt_cell.sv
module q2e_sqrt_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  q2e_pkg::sqrt_type d_in,
   output q2e_pkg::sqrt_type d_out
);

   localparam logic [63:0] BIT = 64'(1) << (62 - 2 * IDX);

   q2e_pkg::sqrt_type q_ff, q_in;
   logic [63:0]       trial;

   always_comb begin
      q_in  = d_in;
      trial = d_in.r + BIT;
      if (d_in.v >= trial) begin
         q_in.v = d_in.v - trial;
         q_in.r = (d_in.r >> 1) + BIT;
      end else begin
         q_in.r = d_in.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.side.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

FILE: rtl/q2e_cordic_cell.sv
module q2e_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  q2e_pkg::cordic_type d_in,
   output q2e_pkg::cordic_type d_out
);

   localparam logic signed [q2e_pkg::ZW-1:0] T = q2e_pkg::atan_q16(STAGE);

   q2e_pkg::cordic_type q_ff, q_in;
   logic signed [q2e_pkg::CW-1:0] xs, ys;

   always_comb begin
      q_in = d_in;
      xs   = d_in.x >>> STAGE;
      ys   = d_in.y >>> STAGE;
      if (!d_in.fix) begin
         if (d_in.y >= 0) begin
            q_in.x = d_in.x + ys;
            q_in.y = d_in.y - xs;
            q_in.z = d_in.z + T;
         end else begin
            q_in.x = d_in.x - ys;
            q_in.y = d_in.y + xs;
            q_in.z = d_in.z - T;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;

endmodule

FILE: rtl/quaternion_to_euler_angles_top.sv
// Stages from req word to rsp word, in order:
// six front stages, 32 square-root cells, one setup stage, the rotation cells, one output.
// Throughput: one word per cycle; the whole chain holds while an rsp word waits.
// Reset: synchronous, clears the valid bits on the path to rsp_valid; no rsp word follows reset.
`include "assert_macros.svh"
module quaternion_to_euler_angles_top #(
   parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  q2e_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output q2e_pkg::rsp_type rsp_data
);

   localparam int ZW  = q2e_pkg::ZW;
   localparam int CW  = q2e_pkg::CW;
   localparam int NSQ = q2e_pkg::SQRT_CELLS;
   localparam int SH  = 16 - ANGLE_FRAC_BITS;
   localparam logic signed [ZW:0] HALF = (ZW+1)'(1) <<< (SH - 1);
   localparam int ROLL_MAX = ((180 << ANGLE_FRAC_BITS) > 32767) ?
                             32767 : (180 << ANGLE_FRAC_BITS);
   localparam int YAW_MAX  = ((360 << ANGLE_FRAC_BITS) > 65535) ?
                             65535 : (360 << ANGLE_FRAC_BITS);

   logic en;
   logic rsp_valid_ff;
   q2e_pkg::rsp_type rsp_data_ff, rsp_data_in;

   q2e_pkg::sqrt_type   sq [0:NSQ];
   q2e_pkg::cordic_type roll_c [0:CORDIC_STAGES];
   q2e_pkg::cordic_type yaw_c  [0:CORDIC_STAGES];
   q2e_pkg::cordic_type pit_c  [0:CORDIC_STAGES];
   q2e_pkg::cordic_type roll_in, yaw_in, pit_in;
   logic signed [CW-1:0] root;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   q2e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid && req_ready),
      .in_data  (req_data),
      .out_data (sq[0])
   );

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      q2e_sqrt_cell #(.IDX(k)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d_in  (sq[k]),
         .d_out (sq[k+1])
      );
   end

   always_comb begin
      root          = CW'(sq[NSQ].r[31:0]) <<< 4;
      roll_in       = q2e_pkg::cordic_init(sq[NSQ].side.roll_y, sq[NSQ].side.roll_x);
      yaw_in        = q2e_pkg::cordic_init(sq[NSQ].side.yaw_y, sq[NSQ].side.yaw_x);
      pit_in        = q2e_pkg::cordic_init(sq[NSQ].side.u, root);
      roll_in.valid = sq[NSQ].side.valid;
      roll_in.tag   = sq[NSQ].side.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_c[0].valid <= 1'b0;
      end else if (en) begin
         roll_c[0] <= roll_in;
         yaw_c[0]  <= yaw_in;
         pit_c[0]  <= pit_in;
      end
   end

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      q2e_cordic_cell #(.STAGE(s)) u_roll (
         .clock (clock), .reset (reset), .en (en),
         .d_in  (roll_c[s]), .d_out (roll_c[s+1])
      );
      q2e_cordic_cell #(.STAGE(s)) u_yaw (
         .clock (clock), .reset (reset), .en (en),
         .d_in  (yaw_c[s]), .d_out (yaw_c[s+1])
      );
      q2e_cordic_cell #(.STAGE(s)) u_pitch (
         .clock (clock), .reset (reset), .en (en),
         .d_in  (pit_c[s]), .d_out (pit_c[s+1])
      );
   end

   function automatic logic signed [ZW:0] to_units(input logic signed [ZW:0] v,
                                                   input logic signed [ZW:0] lo,
                                                   input logic signed [ZW:0] hi,
                                                   input logic signed [ZW:0] flo,
                                                   input logic signed [ZW:0] fhi);
      logic signed [ZW:0] c;
      c = (v < lo) ? lo : ((v > hi) ? hi : v);
      c = (c + HALF) >>> SH;
      c = (c < flo) ? flo : ((c > fhi) ? fhi : c);
      return c;
   endfunction

   logic signed [ZW:0] roll_z, yaw_z, yaw_m, pit_z, pit_m;
   logic signed [ZW:0] roll_u, pit_u, yaw_u;

   always_comb begin
      roll_z = (ZW+1)'(roll_c[CORDIC_STAGES].z);
      yaw_z  = (ZW+1)'(yaw_c[CORDIC_STAGES].z);
      pit_z  = -(ZW+1)'(pit_c[CORDIC_STAGES].z);
      yaw_m  = (yaw_z >= 0) ? (ZW+1)'(q2e_pkg::DEG360) - yaw_z : -yaw_z;
      pit_m  = (pit_z >= 0) ? (ZW+1)'(q2e_pkg::DEG180) - pit_z
                            : -(pit_z + (ZW+1)'(q2e_pkg::DEG180));
      roll_u = to_units(roll_z, -(ZW+1)'(q2e_pkg::DEG180), (ZW+1)'(q2e_pkg::DEG180),
                        -(ZW+1)'(32768), (ZW+1)'(32767));
      pit_u  = to_units(pit_m, -(ZW+1)'(q2e_pkg::DEG180), (ZW+1)'(q2e_pkg::DEG180),
                        -(ZW+1)'(32768), (ZW+1)'(32767));
      yaw_u  = to_units(yaw_m, '0, (ZW+1)'(q2e_pkg::DEG360), '0, (ZW+1)'(65535));
      if (roll_c[CORDIC_STAGES].tag) begin
         rsp_data_in = '0;
         rsp_data_in.zero_norm = 1'b1;
      end else begin
         rsp_data_in.roll_angle  = roll_u[15:0];
         rsp_data_in.pitch_angle = pit_u[15:0];
         rsp_data_in.yaw_angle   = yaw_u[15:0];
         rsp_data_in.zero_norm   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= roll_c[CORDIC_STAGES].valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `Q2E_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "word after reset")
   `Q2E_ASSERT(a_zero_angles, clock, reset, rsp_valid && rsp_data.zero_norm |-> rsp_data.roll_angle == 0 && rsp_data.pitch_angle == 0 && rsp_data.yaw_angle == 0, "zero length with nonzero angle")
   `Q2E_ASSERT(a_roll_range, clock, reset, rsp_valid |-> int'(rsp_data.roll_angle) <= ROLL_MAX && int'(rsp_data.roll_angle) >= -ROLL_MAX, "roll out of range")
   `Q2E_ASSERT(a_yaw_range, clock, reset, rsp_valid |-> int'(rsp_data.yaw_angle) <= YAW_MAX, "yaw out of range")

endmodule

FILE: sim/tb_top.sv
module tb_top;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   q2e_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   q2e_pkg::rsp_type rsp_data;

   quaternion_to_euler_angles_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   localparam longint Q16_DEG = 65536;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint limit(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint arc_step(int i);
      longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return (i < 24) ? steps[i] : 0;
   endfunction

   function automatic longint atan2_degrees(longint y, longint x);
      longint base, z, xs, ys;
      base = 0;
      z = 0;
      if (y == 0) return (x < 0) ? 180 * Q16_DEG : 0;
      if (x == 0) return (y > 0) ? 90 * Q16_DEG : -90 * Q16_DEG;
      if (x < 0) begin
         base = (y >= 0) ? 180 * Q16_DEG : -180 * Q16_DEG;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += arc_step(i);
         end else begin
            x -= ys; y += xs; z -= arc_step(i);
         end
      end
      return base + z;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint to_units(longint v, longint lo, longint hi,
                                       longint flo, longint fhi);
      v = limit(v, lo, hi);
      v = floor_shift(v + (64'sd1 <<< 8), 9);
      return limit(v, flo, fhi);
   endfunction

   function automatic q2e_pkg::rsp_type euler_of(q2e_pkg::req_type q);
      q2e_pkg::rsp_type r;
      longint a, b, c, d, m, n2, u, roll, pitch, yaw;
      longint unsigned p, s;
      r = '0;
      a = longint'(q.quat_x) + q.quat_y;
      b = longint'(q.quat_y) - q.quat_x;
      c = longint'(q.quat_z) - q.quat_w;
      d = longint'(q.quat_w) + q.quat_z;
      if (a == 0 && b == 0 && c == 0 && d == 0) begin
         r.zero_norm = 1'b1;
         return r;
      end
      m = a < 0 ? -a : a;
      if ((b < 0 ? -b : b) > m) m = b < 0 ? -b : b;
      if ((c < 0 ? -c : c) > m) m = c < 0 ? -c : c;
      if ((d < 0 ? -d : d) > m) m = d < 0 ? -d : d;
      while (m < 32768) begin
         m *= 2; a *= 2; b *= 2; c *= 2; d *= 2;
      end
      roll = atan2_degrees(2 * (b * c + a * d), a * a + b * b - c * c - d * d);
      yaw = atan2_degrees(2 * (a * b + c * d), a * a - b * b - c * c + d * d);
      n2 = a * a + b * b + c * c + d * d;
      u = limit(2 * (b * d - a * c), -n2, n2);
      p = longint'(n2 - u) >> 4;
      s = longint'(n2 + u) >> 4;
      pitch = -atan2_degrees(u, longint'(int_sqrt(p * s) << 4));
      yaw = (yaw >= 0) ? 360 * Q16_DEG - yaw : -yaw;
      pitch = (pitch >= 0) ? 180 * Q16_DEG - pitch : -(pitch + 180 * Q16_DEG);
      r.roll_angle = 16'(to_units(roll, -180 * Q16_DEG, 180 * Q16_DEG, -32768, 32767));
      r.pitch_angle = 16'(to_units(pitch, -180 * Q16_DEG, 180 * Q16_DEG, -32768, 32767));
      r.yaw_angle = 16'(to_units(yaw, 0, 360 * Q16_DEG, 0, 65535));
      return r;
   endfunction

   class angle_board;
      q2e_pkg::rsp_type pending[$];
      int errors;
      int checked;

      function void note_quat(q2e_pkg::req_type q);
         pending.push_back(euler_of(q));
      endfunction

      function void check_angles(q2e_pkg::rsp_type got);
         q2e_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected rsp word %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.roll_angle !== want.roll_angle) begin
            $error("roll_angle expected %0d actual %0d", want.roll_angle, got.roll_angle);
            errors++;
         end
         if (got.pitch_angle !== want.pitch_angle) begin
            $error("pitch_angle expected %0d actual %0d", want.pitch_angle, got.pitch_angle);
            errors++;
         end
         if (got.yaw_angle !== want.yaw_angle) begin
            $error("yaw_angle expected %0d actual %0d", want.yaw_angle, got.yaw_angle);
            errors++;
         end
         if (got.zero_norm !== want.zero_norm) begin
            $error("zero_norm expected %0d actual %0d", want.zero_norm, got.zero_norm);
            errors++;
         end
      endfunction
   endclass

   angle_board board = new();
   bit calm = 1'b0;
   int sent = 0;

   task automatic send_quat(q2e_pkg::req_type q);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_quat(q);
      sent++;
   endtask

   function automatic logic [15:0] pick_component();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 6)) - 3);
         3: return 16'($signed(16'($urandom_range(0, 32767))) - 16384);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      q2e_pkg::req_type q;
      logic [15:0] edges[6];
      edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_quat('0);
      send_quat('{16'h4000, 16'h4000, 16'h0, 16'h0});
      send_quat('{16'h0, 16'h0, 16'h2d41, 16'h2d41});
      send_quat('{16'h0, 16'h0, 16'hd2bf, 16'h2d41});
      for (int i = 0; i < 6; i++) begin
         send_quat('{edges[i], 16'h0, 16'h0, 16'h0});
         send_quat('{16'h0, edges[i], 16'h0, 16'h0});
         send_quat('{16'h0, 16'h0, edges[i], edges[(i + 2) % 6]});
      end
      send_quat('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_quat('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      send_quat('{16'h0001, 16'h0001, 16'h0001, 16'h0001});
      for (int n = 0; n < 800; n++) begin
         if (n == 680) calm = 1'b1;
         q.quat_x = pick_component();
         q.quat_y = ($urandom_range(0, 7) == 0) ? -q.quat_x : pick_component();
         q.quat_z = pick_component();
         q.quat_w = ($urandom_range(0, 7) == 0) ? q.quat_z : pick_component();
         send_quat(q);
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("tb: %0d quaternions sent, %0d angle sets checked", sent, board.checked);
      $display("tb: axis, extreme and zero-length cases plus random orientations");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      int hold;
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_angles(rsp_data);
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
